### rtl/bprhs_pkg.sv
// ----------------------------------------------------------------------------
// bprhs_pkg
// Shared types and constants of the bending pin right-hand-side accumulator.
// ----------------------------------------------------------------------------
package bprhs_pkg;

  localparam int NUM_VERTICES = 1024;
  localparam int VTX_W        = $clog2(NUM_VERTICES);
  localparam int POS_W        = 32;
  localparam int K_W          = 32;
  localparam int ACC_W        = 48;
  localparam int CSUM_W       = POS_W + 3;          // a - 2b + c of Q16.16 positions
  localparam int CMAG_W       = POS_W + 2;          // |C| <= 2^33
  localparam int PROD_W       = K_W + CMAG_W;       // k * |C|
  localparam int SCALED_W     = PROD_W + 1;         // times |w| of one or two
  localparam int MAG_W        = SCALED_W - 16;      // rounded to Q32.16
  localparam int FRAC_W       = 16;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_LOAD_PIN  = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_STENCIL   = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_PIN_B,
    ST_PIN_C,
    ST_SUM,
    ST_MUL,
    ST_MUL_DRAIN,
    ST_RMW_RD,
    ST_RMW_WR
  } state_t;

  typedef struct packed {
    logic                    flag;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pin_row_t;

  typedef struct packed {
    logic                    valid;
    logic                    sat;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } rhs_row_t;

endpackage

### rtl/bprhs_req_if.sv
// ----------------------------------------------------------------------------
// bprhs_req_if
// Request channel: one action beat with its vertex, pin and stencil fields.
// ----------------------------------------------------------------------------
interface bprhs_req_if;

  logic                                      valid;
  logic                                      ready;
  bprhs_pkg::action_t                        action;
  logic [bprhs_pkg::VTX_W-1:0]               vertex;
  logic                                      pinned;
  logic signed [bprhs_pkg::POS_W-1:0]        pos_x;
  logic signed [bprhs_pkg::POS_W-1:0]        pos_y;
  logic signed [bprhs_pkg::POS_W-1:0]        pos_z;
  logic [bprhs_pkg::VTX_W-1:0]               vertex_a;
  logic [bprhs_pkg::VTX_W-1:0]               vertex_b;
  logic [bprhs_pkg::VTX_W-1:0]               vertex_c;
  logic [bprhs_pkg::K_W-1:0]                 stiffness;

  modport source (
    output valid, action, vertex, pinned, pos_x, pos_y, pos_z,
           vertex_a, vertex_b, vertex_c, stiffness,
    input  ready
  );

  modport sink (
    input  valid, action, vertex, pinned, pos_x, pos_y, pos_z,
           vertex_a, vertex_b, vertex_c, stiffness,
    output ready
  );

endinterface

### rtl/bprhs_rsp_if.sv
// ----------------------------------------------------------------------------
// bprhs_rsp_if
// Response channel: accumulator contents of one vertex per beat.
// ----------------------------------------------------------------------------
interface bprhs_rsp_if;

  logic                                valid;
  logic                                ready;
  logic signed [bprhs_pkg::ACC_W-1:0]  rhs_x;
  logic signed [bprhs_pkg::ACC_W-1:0]  rhs_y;
  logic signed [bprhs_pkg::ACC_W-1:0]  rhs_z;
  logic                                saturated;

  modport source (
    output valid, rhs_x, rhs_y, rhs_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, rhs_x, rhs_y, rhs_z, saturated,
    output ready
  );

endinterface

### rtl/bprhs_contrib.sv
// ----------------------------------------------------------------------------
// bprhs_contrib
// One axis of a stencil contribution: scales k*|C| by the vertex weight,
// rounds to Q32.16 half away from zero, applies the sign and clamps.
// ----------------------------------------------------------------------------
module bprhs_contrib (
  input  logic [bprhs_pkg::PROD_W-1:0]        prod,
  input  logic                                c_neg,
  input  logic                                w_neg,
  input  logic                                w_two,
  output logic signed [bprhs_pkg::ACC_W-1:0]  delta,
  output logic                                sat
);

  localparam logic [bprhs_pkg::MAG_W-1:0] POS_LIMIT =
    bprhs_pkg::MAG_W'({1'b0, {(bprhs_pkg::ACC_W-1){1'b1}}});
  localparam logic [bprhs_pkg::MAG_W-1:0] NEG_LIMIT =
    bprhs_pkg::MAG_W'({1'b1, {(bprhs_pkg::ACC_W-1){1'b0}}});
  localparam logic [bprhs_pkg::SCALED_W-1:0] HALF =
    bprhs_pkg::SCALED_W'(1) << (bprhs_pkg::FRAC_W - 1);

  logic [bprhs_pkg::SCALED_W-1:0] scaled;
  logic [bprhs_pkg::SCALED_W-1:0] rnd;
  logic [bprhs_pkg::MAG_W-1:0]    mag;
  logic                           pos;

  assign scaled = w_two ? {prod, 1'b0} : {1'b0, prod};
  assign rnd    = scaled + HALF;
  assign mag    = rnd[bprhs_pkg::SCALED_W-1:bprhs_pkg::FRAC_W];
  // -k*w*C is positive when exactly one of C and w is negative
  assign pos    = c_neg != w_neg;

  always_comb begin
    sat   = 1'b0;
    delta = '0;
    if (pos) begin
      if (mag > POS_LIMIT) begin
        sat   = 1'b1;
        delta = bprhs_pkg::ACC_MAX;
      end else begin
        delta = mag[bprhs_pkg::ACC_W-1:0];
      end
    end else begin
      if (mag > NEG_LIMIT) begin
        sat   = 1'b1;
        delta = bprhs_pkg::ACC_MIN;
      end else begin
        delta = -mag[bprhs_pkg::ACC_W-1:0];
      end
    end
  end

endmodule

### rtl/bending_pin_rhs_accumulator_core.sv
// ----------------------------------------------------------------------------
// bending_pin_rhs_accumulator_core
// Per-vertex pin store and saturating right-hand-side accumulator for
// bending stencils.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories with req.ready low, then takes
// one request at a time. A pin load is written as it is accepted. A clear
// sweeps the accumulator memory one row a cycle. A read passes the memory
// read register and lands in an output register, so the next request is taken
// while the response beat still waits. A stencil with zero stiffness is
// dropped in ST_IDLE; otherwise the pin memory is read for a, b and c, and
// if any of them is pinned the shared 32x32 multiplier forms k*|C| for the
// three axes, then each stencil slot is skipped when pinned and costs a read
// plus a write-back of the accumulator row when free. Each memory has a single
// read and write port; a write-back always lands before the next row read, so
// a vertex that occurs twice in a stencil sees its own first update.
// ----------------------------------------------------------------------------
module bending_pin_rhs_accumulator_core (
  input  logic         clk,
  input  logic         rst,
  bprhs_req_if.sink    req,
  bprhs_rsp_if.source  rsp
);

  localparam logic [bprhs_pkg::VTX_W-1:0] LAST_ROW =
    bprhs_pkg::VTX_W'(bprhs_pkg::NUM_VERTICES - 1);

  // memories
  bprhs_pkg::pin_row_t pin_mem [bprhs_pkg::NUM_VERTICES];
  bprhs_pkg::rhs_row_t rhs_mem [bprhs_pkg::NUM_VERTICES];

  bprhs_pkg::state_t state;
  bprhs_pkg::state_t state_next;

  logic                         pin_rd_en;
  logic [bprhs_pkg::VTX_W-1:0]  pin_rd_addr;
  bprhs_pkg::pin_row_t          pin_rd;
  logic                         pin_we;
  logic [bprhs_pkg::VTX_W-1:0]  pin_wa;
  bprhs_pkg::pin_row_t          pin_wd;

  logic                         rhs_rd_en;
  logic [bprhs_pkg::VTX_W-1:0]  rhs_rd_addr;
  bprhs_pkg::rhs_row_t          rhs_rd;
  logic                         rhs_we;
  logic [bprhs_pkg::VTX_W-1:0]  rhs_wa;
  bprhs_pkg::rhs_row_t          rhs_wd;

  logic                         accept;
  logic [bprhs_pkg::VTX_W-1:0]  cnt;

  // stencil context
  logic [bprhs_pkg::VTX_W-1:0]  vtx [3];
  logic [bprhs_pkg::K_W-1:0]    k;
  logic [2:0]                   flg;
  logic [1:0]                   idx;
  logic signed [bprhs_pkg::CSUM_W-1:0] csum [3];
  logic signed [bprhs_pkg::CSUM_W-1:0] pin_q [3];
  logic                         any_pinned;

  // multiplier
  logic [1:0]                   mul_axis;
  logic [1:0]                   mul_axis_d;
  logic                         mul_vld;
  logic signed [bprhs_pkg::CSUM_W-1:0] mul_c;
  logic [bprhs_pkg::CSUM_W-1:0] mul_neg;
  logic [bprhs_pkg::CMAG_W-1:0] mul_mag;
  logic [2*bprhs_pkg::K_W-1:0]  prod_lo;
  logic [bprhs_pkg::K_W+1:0]    prod_hi;
  logic [bprhs_pkg::PROD_W-1:0] prod [3];

  // contribution
  logic                         w_neg;
  logic                         w_two;
  logic signed [bprhs_pkg::ACC_W-1:0] delta_c [3];
  logic [2:0]                   sat_c;
  logic signed [bprhs_pkg::ACC_W-1:0] delta [3];
  logic                         delta_sat;

  // write-back
  logic signed [bprhs_pkg::ACC_W-1:0] old_v [3];
  logic signed [bprhs_pkg::ACC_W:0]   sum_v [3];
  logic signed [bprhs_pkg::ACC_W-1:0] new_v [3];
  logic [2:0]                         add_sat;

  // response register
  logic                         out_vld;
  logic                         out_load;

  assign accept = req.valid && req.ready;

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (pin_we) begin
      pin_mem[pin_wa] <= pin_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pin_rd_en) begin
      pin_rd <= pin_mem[pin_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rhs_we) begin
      rhs_mem[rhs_wa] <= rhs_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rhs_rd_en) begin
      rhs_rd <= rhs_mem[rhs_rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  assign any_pinned = flg[0] || flg[1] || pin_rd.flag;

  always_comb begin
    state_next = state;
    case (state)
      bprhs_pkg::ST_INIT: begin
        if (cnt == LAST_ROW) state_next = bprhs_pkg::ST_IDLE;
      end
      bprhs_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.action)
            bprhs_pkg::ACT_CLEAR:   state_next = bprhs_pkg::ST_CLEAR;
            bprhs_pkg::ACT_READ:    state_next = bprhs_pkg::ST_READ;
            bprhs_pkg::ACT_STENCIL: begin
              if (req.stiffness != '0) state_next = bprhs_pkg::ST_PIN_B;
            end
            default: state_next = bprhs_pkg::ST_IDLE;
          endcase
        end
      end
      bprhs_pkg::ST_CLEAR: begin
        if (cnt == LAST_ROW) state_next = bprhs_pkg::ST_IDLE;
      end
      bprhs_pkg::ST_READ: begin
        if (out_load) state_next = bprhs_pkg::ST_IDLE;
      end
      bprhs_pkg::ST_PIN_B:     state_next = bprhs_pkg::ST_PIN_C;
      bprhs_pkg::ST_PIN_C:     state_next = bprhs_pkg::ST_SUM;
      bprhs_pkg::ST_SUM: begin
        state_next = any_pinned ? bprhs_pkg::ST_MUL : bprhs_pkg::ST_IDLE;
      end
      bprhs_pkg::ST_MUL: begin
        if (mul_axis == 2'd2) state_next = bprhs_pkg::ST_MUL_DRAIN;
      end
      bprhs_pkg::ST_MUL_DRAIN: state_next = bprhs_pkg::ST_RMW_RD;
      bprhs_pkg::ST_RMW_RD: begin
        if (!flg[idx]) begin
          state_next = bprhs_pkg::ST_RMW_WR;
        end else if (idx == 2'd2) begin
          state_next = bprhs_pkg::ST_IDLE;
        end
      end
      bprhs_pkg::ST_RMW_WR: begin
        state_next = (idx == 2'd2) ? bprhs_pkg::ST_IDLE : bprhs_pkg::ST_RMW_RD;
      end
      default: state_next = bprhs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bprhs_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // outputs of the sequencer: handshake and memory ports
  // --------------------------------------------------------------------------
  always_comb begin
    req.ready   = 1'b0;
    pin_rd_en   = 1'b0;
    pin_rd_addr = req.vertex_a;
    pin_we      = 1'b0;
    pin_wa      = req.vertex;
    pin_wd      = '{flag: req.pinned, x: req.pos_x, y: req.pos_y, z: req.pos_z};
    rhs_rd_en   = 1'b0;
    rhs_rd_addr = req.vertex;
    rhs_we      = 1'b0;
    rhs_wa      = vtx[idx];
    rhs_wd      = '{valid: 1'b1, sat: rhs_rd.valid && rhs_rd.sat || delta_sat ||
                    (add_sat != '0), x: new_v[0], y: new_v[1], z: new_v[2]};
    out_load    = 1'b0;
    case (state)
      bprhs_pkg::ST_INIT: begin
        pin_we = 1'b1;
        pin_wa = cnt;
        pin_wd = '0;
        rhs_we = 1'b1;
        rhs_wa = cnt;
        rhs_wd = '0;
      end
      bprhs_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        pin_rd_en = accept && (req.action == bprhs_pkg::ACT_STENCIL);
        rhs_rd_en = accept && (req.action == bprhs_pkg::ACT_READ);
        pin_we    = accept && (req.action == bprhs_pkg::ACT_LOAD_PIN);
      end
      bprhs_pkg::ST_CLEAR: begin
        rhs_we = 1'b1;
        rhs_wa = cnt;
        rhs_wd = '0;
      end
      bprhs_pkg::ST_READ: begin
        out_load = !out_vld || rsp.ready;
      end
      bprhs_pkg::ST_PIN_B: begin
        pin_rd_en   = 1'b1;
        pin_rd_addr = vtx[1];
      end
      bprhs_pkg::ST_PIN_C: begin
        pin_rd_en   = 1'b1;
        pin_rd_addr = vtx[2];
      end
      bprhs_pkg::ST_RMW_RD: begin
        rhs_rd_en   = !flg[idx];
        rhs_rd_addr = vtx[idx];
      end
      bprhs_pkg::ST_RMW_WR: begin
        rhs_we = 1'b1;
      end
      default: ;
    endcase
  end

  // sweep counter wraps to zero at the end of each pass
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == bprhs_pkg::ST_INIT || state == bprhs_pkg::ST_CLEAR) begin
      cnt <= cnt + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // pin sum C, one stencil slot per cycle as the pin rows arrive
  // --------------------------------------------------------------------------
  assign pin_q[0] = bprhs_pkg::CSUM_W'(pin_rd.x);
  assign pin_q[1] = bprhs_pkg::CSUM_W'(pin_rd.y);
  assign pin_q[2] = bprhs_pkg::CSUM_W'(pin_rd.z);

  always_ff @(posedge clk) begin
    if (accept) begin
      vtx[0] <= req.vertex_a;
      vtx[1] <= req.vertex_b;
      vtx[2] <= req.vertex_c;
      k      <= req.stiffness;
    end
    for (int a = 0; a < 3; a++) begin
      case (state)
        bprhs_pkg::ST_PIN_B: csum[a] <= pin_rd.flag ? pin_q[a] : '0;
        bprhs_pkg::ST_PIN_C: begin
          if (pin_rd.flag) csum[a] <= csum[a] - (pin_q[a] <<< 1);
        end
        bprhs_pkg::ST_SUM: begin
          if (pin_rd.flag) csum[a] <= csum[a] + pin_q[a];
        end
        default: ;
      endcase
    end
    case (state)
      bprhs_pkg::ST_PIN_B: flg[0] <= pin_rd.flag;
      bprhs_pkg::ST_PIN_C: flg[1] <= pin_rd.flag;
      bprhs_pkg::ST_SUM:   flg[2] <= pin_rd.flag;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // k*|C| per axis on one multiplier, split at bit 32 of |C|
  // --------------------------------------------------------------------------
  assign mul_c   = csum[mul_axis];
  assign mul_neg = -mul_c;
  assign mul_mag = mul_c[bprhs_pkg::CSUM_W-1] ? mul_neg[bprhs_pkg::CMAG_W-1:0]
                                               : mul_c[bprhs_pkg::CMAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else begin
      mul_vld <= (state == bprhs_pkg::ST_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (state == bprhs_pkg::ST_MUL) begin
      mul_axis <= mul_axis + 1'b1;
    end else begin
      mul_axis <= '0;
    end
    mul_axis_d <= mul_axis;
    prod_lo    <= k * mul_mag[bprhs_pkg::K_W-1:0];
    prod_hi    <= k * mul_mag[bprhs_pkg::CMAG_W-1:bprhs_pkg::K_W];
    if (mul_vld) begin
      prod[mul_axis_d] <= bprhs_pkg::PROD_W'(prod_lo) +
                          (bprhs_pkg::PROD_W'(prod_hi) << bprhs_pkg::K_W);
    end
  end

  // --------------------------------------------------------------------------
  // accumulator updates in order a, b, c; pinned slots are skipped
  // --------------------------------------------------------------------------
  assign w_neg = (idx == 2'd1);
  assign w_two = (idx == 2'd1);

  for (genvar g = 0; g < 3; g++) begin : g_axis
    bprhs_contrib u_contrib (
      .prod  (prod[g]),
      .c_neg (csum[g][bprhs_pkg::CSUM_W-1]),
      .w_neg (w_neg),
      .w_two (w_two),
      .delta (delta_c[g]),
      .sat   (sat_c[g])
    );
  end

  always_ff @(posedge clk) begin
    if (state == bprhs_pkg::ST_RMW_RD) begin
      delta     <= delta_c;
      delta_sat <= sat_c != '0;
    end
    case (state)
      bprhs_pkg::ST_MUL_DRAIN: idx <= '0;
      bprhs_pkg::ST_RMW_RD: begin
        if (flg[idx]) idx <= idx + 1'b1;
      end
      bprhs_pkg::ST_RMW_WR: idx <= idx + 1'b1;
      default: ;
    endcase
  end

  // a row without its valid bit adds from zero
  assign old_v[0] = rhs_rd.valid ? rhs_rd.x : '0;
  assign old_v[1] = rhs_rd.valid ? rhs_rd.y : '0;
  assign old_v[2] = rhs_rd.valid ? rhs_rd.z : '0;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_v[a]   = (bprhs_pkg::ACC_W+1)'(old_v[a]) + (bprhs_pkg::ACC_W+1)'(delta[a]);
      add_sat[a] = sum_v[a][bprhs_pkg::ACC_W] != sum_v[a][bprhs_pkg::ACC_W-1];
      if (add_sat[a]) begin
        new_v[a] = sum_v[a][bprhs_pkg::ACC_W] ? bprhs_pkg::ACC_MIN : bprhs_pkg::ACC_MAX;
      end else begin
        new_v[a] = sum_v[a][bprhs_pkg::ACC_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.rhs_x     <= old_v[0];
      rsp.rhs_y     <= old_v[1];
      rsp.rhs_z     <= old_v[2];
      rsp.saturated <= rhs_rd.valid && rhs_rd.sat;
    end
  end

  assign rsp.valid = out_vld;

endmodule
